### rtl/lz_zero_run_decompressor_assert.svh
// ----------------------------------------------------------------------------
// lz_zero_run_decompressor_assert.svh
// Assertion macros for the zero-run decompressor; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef LZ_ZERO_RUN_DECOMPRESSOR_ASSERT_SVH
`define LZ_ZERO_RUN_DECOMPRESSOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LZD_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lzd: assertion failed");
// next-cycle implication
`define LZD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lzd: assertion failed");
`else
`define LZD_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define LZD_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### rtl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants of the zero-run decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

	localparam int WINDOW_DEPTH = 256;
	localparam int BEAT_BYTES   = 8;
	localparam int OUT_DATA_W   = 64;
	localparam int LEN_W        = 16;
	localparam int RUN_LEN_W    = 9;

	localparam logic [LEN_W-1:0] OUT_LENGTH_RESET = 16'd772;
	localparam logic [2:0]       LIT_COUNT_MASK   = 3'h7;
	localparam int               COPY_FLAG_BIT    = 3;
	localparam int               RUN_NIBBLE_SHIFT = 4;
	localparam logic [RUN_LEN_W-1:0] COPY_BIAS    = 9'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_stream;
	} in_t;

	typedef struct packed {
		logic [OUT_DATA_W-1:0] out_data;
		logic [3:0]            valid_bytes;
		logic                  last_of_run;
		logic                  stream_done;
	} out_t;

	// what one accepted byte asks of the emitter
	typedef struct packed {
		logic                 emit_lit;
		logic [7:0]           lit_byte;
		logic                 zero_run;
		logic                 copy_run;
		logic [RUN_LEN_W-1:0] run_len;
		logic [7:0]           back_dist;
	} act_t;

endpackage

### rtl/lzd_ram.sv
// ----------------------------------------------------------------------------
// lzd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lzd_pkg::WINDOW_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/lzd_parser.sv
// ----------------------------------------------------------------------------
// lzd_parser
// Token parser: tracks header, counts and phase; decodes each item into
// an action for the byte emitter.
// ----------------------------------------------------------------------------
module lzd_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          sos,
	input  logic          active,
	input  logic [7:0]    in_byte,
	output lzd_pkg::act_t act
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LITCOUNT,
		PH_RUNCOUNT,
		PH_LITERALS,
		PH_OFFSET
	} phase_t;

	phase_t     phase_q, phase_d, phase_cur;
	logic [7:0] hdr_q, hdr_d;
	logic [7:0] lit_q, lit_d;
	logic [7:0] run_q, run_d;
	logic       then_counts;
	logic       then_literals;

	function automatic logic [7:0] lit_from(input logic [7:0] c);
		lit_from = (c > 8'd1) ? 8'(c - 8'd1) : 8'd0;
	endfunction

	always_comb begin
		phase_cur     = sos ? PH_HEADER : phase_q;
		phase_d       = phase_cur;
		hdr_d         = hdr_q;
		lit_d         = lit_q;
		run_d         = run_q;
		then_counts   = 1'b0;
		then_literals = 1'b0;
		act           = '0;
		act.lit_byte  = in_byte;
		act.back_dist = in_byte;

		if (active) begin
			unique case (phase_cur)
				PH_HEADER: begin
					hdr_d = in_byte;
					run_d = 8'(in_byte >> lzd_pkg::RUN_NIBBLE_SHIFT);
					if ((in_byte[2:0] & lzd_pkg::LIT_COUNT_MASK) == 3'd0) begin
						phase_d = PH_LITCOUNT;
					end else begin
						lit_d = lit_from({5'd0, in_byte[2:0]});
						if (in_byte[7:4] == 4'd0) begin
							phase_d = PH_RUNCOUNT;
						end else begin
							then_counts = 1'b1;
						end
					end
				end
				PH_LITCOUNT: begin
					lit_d = lit_from(in_byte);
					if (hdr_q[7:4] == 4'd0) begin
						phase_d = PH_RUNCOUNT;
					end else begin
						then_counts = 1'b1;
					end
				end
				PH_RUNCOUNT: begin
					run_d       = in_byte;
					then_counts = 1'b1;
				end
				PH_LITERALS: begin
					act.emit_lit = 1'b1;
					lit_d        = lit_q - 8'd1;
					if (lit_d == 8'd0) begin
						then_literals = 1'b1;
					end
				end
				PH_OFFSET: begin
					act.copy_run = 1'b1;
					act.run_len  = {1'b0, run_q} + lzd_pkg::COPY_BIAS;
					phase_d      = PH_HEADER;
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase

			if (then_counts) begin
				if (lit_d != 8'd0) begin
					phase_d = PH_LITERALS;
				end else begin
					then_literals = 1'b1;
				end
			end
			if (then_literals) begin
				if (hdr_d[lzd_pkg::COPY_FLAG_BIT]) begin
					phase_d = PH_OFFSET;
				end else begin
					act.zero_run = 1'b1;
					act.run_len  = {1'b0, run_d};
					phase_d      = PH_HEADER;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= '0;
			lit_q   <= '0;
			run_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			lit_q   <= lit_d;
			run_q   <= run_d;
		end
	end

endmodule

### rtl/lzd_emitter.sv
// ----------------------------------------------------------------------------
// lzd_emitter
// Byte emitter: one byte per step into the window and the beat packer,
// zero runs and window copies under a small sequencer, output register.
// ----------------------------------------------------------------------------
`include "lz_zero_run_decompressor_assert.svh"

module lzd_emitter #(
	parameter int WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH,
	parameter int BEAT_BYTES   = lzd_pkg::BEAT_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            sos,
	input  lzd_pkg::act_t                   act,
	input  logic [lzd_pkg::LEN_W-1:0]       out_length,
	output logic                            active,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lzd_pkg::out_t                   out_item,
	output logic                            ram_we,
	output logic [$clog2(WINDOW_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                      ram_wdata,
	output logic [$clog2(WINDOW_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                      ram_rdata
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(BEAT_BYTES + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(BEAT_BYTES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ZERO,
		S_CRD,
		S_CWR,
		S_FLUSH
	} state_t;

	state_t                            state_q, state_d;
	logic [lzd_pkg::LEN_W-1:0]         pos_q, pos_d, pos_base, pos_cur;
	logic [lzd_pkg::RUN_LEN_W-1:0]     rem_q, rem_d;
	logic [7:0]                        dist_q, dist_d;
	logic [lzd_pkg::OUT_DATA_W-1:0]    acc_q, acc_d;
	logic [CW-1:0]                     cnt_q, cnt_d;
	logic                              out_valid_q, out_valid_d;
	lzd_pkg::out_t                     out_q, out_d;
	logic                              accept, more, slot_free;
	logic                              emit, push, push_last;
	logic [7:0]                        emit_byte;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign pos_base  = sos ? '0 : pos_q;
	assign active    = (pos_base < out_length);
	assign pos_cur   = (state_q == S_IDLE) ? pos_base : pos_q;
	assign more      = (rem_q != '0) && (pos_q < out_length);
	assign slot_free = !out_valid_q || out_ready;
	assign ram_raddr = AW'(pos_q - {8'd0, dist_q});
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		state_d     = state_q;
		pos_d       = pos_q;
		rem_d       = rem_q;
		dist_d      = dist_q;
		acc_d       = acc_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q;
		out_d       = out_q;
		emit        = 1'b0;
		emit_byte   = 8'd0;
		push        = 1'b0;
		push_last   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_d = pos_base;
					if (active) begin
						rem_d  = act.run_len;
						dist_d = act.back_dist;
						if (act.emit_lit) begin
							emit      = 1'b1;
							emit_byte = act.lit_byte;
						end
						if (act.zero_run && act.run_len != '0) begin
							state_d = S_ZERO;
						end else if (act.copy_run) begin
							state_d = S_CRD;
						end else if (act.emit_lit) begin
							state_d = S_FLUSH;
						end
					end
				end
			end
			S_ZERO: begin
				if (!more) begin
					state_d = S_FLUSH;
				end else if (cnt_q == CNT_FULL) begin
					push = slot_free;
				end else begin
					emit  = 1'b1;
					rem_d = rem_q - lzd_pkg::RUN_LEN_W'(1);
				end
			end
			S_CRD: begin
				if (!more) begin
					state_d = S_FLUSH;
				end else if (cnt_q == CNT_FULL) begin
					push = slot_free;
				end else begin
					state_d = S_CWR;
				end
			end
			S_CWR: begin
				// offset zero copies zeros
				emit      = 1'b1;
				emit_byte = (dist_q == 8'd0) ? 8'd0 : ram_rdata;
				rem_d     = rem_q - lzd_pkg::RUN_LEN_W'(1);
				state_d   = S_CRD;
			end
			S_FLUSH: begin
				if (cnt_q == '0) begin
					state_d = S_IDLE;
				end else if (slot_free) begin
					push      = 1'b1;
					push_last = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (emit) begin
			for (int i = 0; i < BEAT_BYTES; i++) begin
				if (cnt_q == CW'(i)) begin
					acc_d[i*8 +: 8] = emit_byte;
				end
			end
			cnt_d = cnt_q + CW'(1);
			pos_d = pos_cur + lzd_pkg::LEN_W'(1);
		end

		if (push) begin
			out_d.out_data    = acc_q;
			out_d.valid_bytes = 4'(cnt_q);
			out_d.last_of_run = push_last;
			out_d.stream_done = push_last && (pos_q >= out_length);
			out_valid_d       = 1'b1;
			acc_d             = '0;
			cnt_d             = '0;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	assign ram_we    = emit;
	assign ram_waddr = pos_cur[AW-1:0];
	assign ram_wdata = emit_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			rem_q       <= '0;
			dist_q      <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			state_q     <= state_d;
			pos_q       <= pos_d;
			rem_q       <= rem_d;
			dist_q      <= dist_d;
			acc_q       <= acc_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
			out_q       <= out_d;
		end
	end

	`LZD_ASSERT_IMPLIES(a_idle_acc_empty, clk, arst_n, state_q == S_IDLE, cnt_q == '0)
	`LZD_ASSERT_IMPLIES(a_out_nonempty, clk, arst_n, out_valid_q, out_q.valid_bytes != 4'd0)
	`LZD_ASSERT_IMPLIES(a_pos_bound, clk, arst_n, state_q != S_IDLE, pos_q <= out_length)
	`LZD_ASSERT_IMPLIES(a_cwr_after_crd, clk, arst_n, state_q == S_CWR, $past(state_q) == S_CRD)
	`LZD_ASSERT_IMPLIES(a_done_is_last, clk, arst_n, out_valid_q && out_q.stream_done, out_q.last_of_run)

endmodule

### rtl/lz_zero_run_decompressor.sv
// ----------------------------------------------------------------------------
// lz_zero_run_decompressor
// Zero-run / back-reference decompressor with a 256-byte history window.
// ----------------------------------------------------------------------------
// One item at a time: a header, count or ignored byte is only taken; a literal is
// emitted, then its beat is flushed. A run of output bytes ending an item gives
// zeros, or for a copy a window read, then a write, per byte, then a flush; a stalled
// output adds its wait. A beat is registered and is valid in the cycle after it is
// packed. Reset clears control state and sets out_length to 772; the window is
// not cleared and holds no defined contents.
module lz_zero_run_decompressor #(
	parameter int WINDOW_DEPTH = lzd_pkg::WINDOW_DEPTH,
	parameter int BEAT_BYTES   = lzd_pkg::BEAT_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  lzd_pkg::in_t              in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output lzd_pkg::out_t             out_item,
	input  logic                      cfg_we,
	input  logic [lzd_pkg::LEN_W-1:0] cfg_wdata
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [lzd_pkg::LEN_W-1:0] out_length_q;
	lzd_pkg::act_t             act;
	logic                      active;
	logic                      accept;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr, ram_raddr;
	logic [7:0]                ram_wdata, ram_rdata;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_length_q <= lzd_pkg::OUT_LENGTH_RESET;
		end else if (cfg_we) begin
			out_length_q <= cfg_wdata;
		end
	end

	lzd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.sos     (in_item.start_of_stream),
		.active  (active),
		.in_byte (in_item.in_byte),
		.act     (act)
	);

	lzd_emitter #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.BEAT_BYTES   (BEAT_BYTES)
	) u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sos        (in_item.start_of_stream),
		.act        (act),
		.out_length (out_length_q),
		.active     (active),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	lzd_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### verif/tb_lz_zero_run_decompressor.sv
// ----------------------------------------------------------------------------
// tb_lz_zero_run_decompressor
// Self-checking bench for the zero-run decompressor. A directed table covers
// the corner cases of the token format. Random token streams follow under
// four handshake idling phases. Every output beat is compared with an expected
// beat from the table or from a decoder model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_lz_zero_run_decompressor;
	timeunit 1ns;
	timeprecision 1ps;

	import lzd_pkg::*;

	localparam int DRAIN_CYCLES    = 1200;	// longest copy, with a window read and a write per byte, plus beats
	localparam int ITEMS_PER_PHASE = 26;
	localparam int IDLE_PCT [4]    = '{0, 45, 0, 38};
	localparam int STALL_PCT [4]   = '{0, 0, 45, 38};

	// how a table row gets its expected beats
	localparam int BY_MODEL = -1;
	localparam int NO_BEATS = 0;
	localparam int ONE_BEAT = 1;

	typedef enum logic [2:0] {
		WANT_HEADER, WANT_LIT_COUNT, WANT_RUN_COUNT, WANT_LITERAL, WANT_OFFSET
	} parse_e;

	typedef enum logic {ROW_BYTE, ROW_LENGTH} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic [15:0] val;
		logic        sos;
		int          beats;
		out_t        beat;
	} row_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_item   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_item;
	logic             cfg_we    = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;

	int idle_pct   = 0;
	int stall_pct  = 0;
	int errors     = 0;
	int used_items = 0;

	// decoder model state
	parse_e               parse_st  = WANT_HEADER;
	logic [7:0]           tok_hdr   = '0;
	logic [7:0]           lits_left = '0;
	logic [RUN_LEN_W-1:0] run_len   = '0;
	logic [LEN_W-1:0]     out_pos   = '0;
	logic [LEN_W-1:0]     out_len   = OUT_LENGTH_RESET;
	logic [7:0]           window [WINDOW_DEPTH];
	logic [7:0]           made [$];
	out_t                 fresh_beats [$];
	out_t                 expected_beats [$];
	out_t                 want;
	row_t                 rows [28];

	lz_zero_run_decompressor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// bytes past the length are dropped and never reach the window
	function automatic void put_byte(logic [7:0] b);
		if (out_pos < out_len) begin
			window[out_pos[7:0]] = b;
			made.push_back(b);
			out_pos++;
		end
	endfunction

	function automatic void set_lits(logic [7:0] c);
		lits_left = (c > 8'd1) ? c - 8'd1 : 8'd0;
	endfunction

	function automatic void finish_token();
		if (tok_hdr[COPY_FLAG_BIT]) begin
			parse_st = WANT_OFFSET;
		end else begin
			for (int i = 0; i < run_len; i++)
				put_byte(8'h00);
			parse_st = WANT_HEADER;
		end
	endfunction

	function automatic void counts_done();
		if (lits_left != 0)
			parse_st = WANT_LITERAL;
		else
			finish_token();
	endfunction

	// returns 0 when the byte is ignored (length reached)
	function automatic bit decode_byte(in_t it);
		logic [7:0] b;
		logic [7:0] src;
		int         n;
		out_t       bt;
		b = it.in_byte;
		made.delete();
		fresh_beats.delete();
		if (it.start_of_stream) begin
			parse_st = WANT_HEADER;
			out_pos  = '0;
		end
		if (out_pos >= out_len)
			return 1'b0;
		case (parse_st)
			WANT_HEADER: begin
				tok_hdr = b;
				run_len = RUN_LEN_W'(b[7:4]);
				if (b[2:0] == 3'd0) begin
					parse_st = WANT_LIT_COUNT;
				end else begin
					set_lits({5'd0, b[2:0]});
					if (run_len == 0)
						parse_st = WANT_RUN_COUNT;
					else
						counts_done();
				end
			end
			WANT_LIT_COUNT: begin
				set_lits(b);
				if (tok_hdr[7:4] == 4'd0)
					parse_st = WANT_RUN_COUNT;
				else
					counts_done();
			end
			WANT_RUN_COUNT: begin
				run_len = RUN_LEN_W'(b);
				counts_done();
			end
			WANT_LITERAL: begin
				put_byte(b);
				lits_left--;
				if (lits_left == 0)
					finish_token();
			end
			WANT_OFFSET: begin
				// byte by byte, so an overlapping copy rereads its own output
				for (int i = 0; i < run_len + 2; i++) begin
					src = out_pos[7:0] - b;
					put_byte((b == 8'd0) ? 8'h00 : window[src]);
				end
				parse_st = WANT_HEADER;
			end
			default: parse_st = WANT_HEADER;
		endcase
		for (int k = 0; k < made.size(); k += BEAT_BYTES) begin
			bt = '0;
			n  = made.size() - k;
			if (n > BEAT_BYTES)
				n = BEAT_BYTES;
			for (int j = 0; j < n; j++)
				bt.out_data[8*j +: 8] = made[k + j];
			bt.valid_bytes = 4'(n);
			bt.last_of_run = (k + BEAT_BYTES >= made.size());
			bt.stream_done = bt.last_of_run && (out_pos >= out_len);
			fresh_beats.push_back(bt);
		end
		return 1'b1;
	endfunction

	task automatic feed(input logic [7:0] b, input logic sos,
	                    input int typed = BY_MODEL, input out_t typed_beat = '0);
		in_t it;
		it.in_byte         = b;
		it.start_of_stream = sos;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (decode_byte(it))
			used_items++;
		if (typed == BY_MODEL) begin
			foreach (fresh_beats[i])
				expected_beats.push_back(fresh_beats[i]);
		end else if (typed == ONE_BEAT) begin
			expected_beats.push_back(typed_beat);
		end
	endtask

	task automatic set_length(input logic [LEN_W-1:0] len);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we  <= 1'b0;
		out_len = len;
	endtask

	// one well-formed token with random content, sometimes cut short or
	// replaced by raw noise; the window is fully written by the table first
	task automatic random_token();
		logic [7:0] hdr;
		logic [7:0] lit_cnt;
		logic       sos;
		int         cut;
		int         nlit;
		sos = (parse_st != WANT_HEADER) || (out_pos >= out_len) || ($urandom_range(19) == 0);
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(1, 3)) feed(8'($urandom), $urandom_range(3) == 0);
			return;
		end
		if (out_pos >= out_len && $urandom_range(2) == 0)
			feed(8'($urandom), 1'b0);
		cut = ($urandom_range(11) == 0) ? $urandom_range(0, 2) : 1000;
		hdr = 8'($urandom);
		if ($urandom_range(3) == 0)
			hdr[2:0] = 3'd0;
		if ($urandom_range(3) == 0)
			hdr[7:4] = 4'd0;
		lit_cnt = {5'd0, hdr[2:0]};
		feed(hdr, sos);
		if (hdr[2:0] == 3'd0) begin
			lit_cnt = 8'($urandom_range(9));
			if (cut-- > 0)
				feed(lit_cnt, 1'b0);
		end
		if (hdr[7:4] == 4'd0 && cut-- > 0)
			feed(($urandom_range(15) == 0) ? 8'hFF : 8'($urandom_range(24)), 1'b0);
		nlit = (lit_cnt > 8'd1) ? lit_cnt - 1 : 0;
		for (int i = 0; i < nlit; i++)
			if (cut-- > 0)
				feed(8'($urandom), 1'b0);
		if (hdr[COPY_FLAG_BIT] && cut-- > 0)
			feed(($urandom_range(3) == 0) ? 8'($urandom_range(8)) : 8'($urandom), 1'b0);
	endtask

	initial begin
		int goal;
		rows = '{
			// first output after reset: one literal then a one-byte zero run
			'{ROW_BYTE, 16'h0012, 1'b1, NO_BEATS, '0},
			'{ROW_BYTE, 16'h00FF, 1'b0, ONE_BEAT, '{64'h00FF, 4'd2, 1'b1, 1'b0}},
			// longest zero run; afterwards every window entry has been written
			'{ROW_BYTE, 16'h0001, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h00FF, 1'b0, BY_MODEL, '0},
			// two literals, then an overlapping copy at distance 1
			'{ROW_BYTE, 16'h000B, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0000, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h00A5, 1'b0, ONE_BEAT, '{64'h00A5, 4'd1, 1'b1, 1'b0}},
			'{ROW_BYTE, 16'h005A, 1'b0, ONE_BEAT, '{64'h005A, 4'd1, 1'b1, 1'b0}},
			'{ROW_BYTE, 16'h0001, 1'b0, ONE_BEAT, '{64'h5A5A, 4'd2, 1'b1, 1'b0}},
			// both count bytes present, offset zero gives zeros
			'{ROW_BYTE, 16'h0008, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0000, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0003, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0000, 1'b0, ONE_BEAT, '{64'h0, 4'd5, 1'b1, 1'b0}},
			// longest copy, 33 beats
			'{ROW_BYTE, 16'h0009, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h00FF, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0080, 1'b0, BY_MODEL, '0},
			// empty token: nothing produced
			'{ROW_BYTE, 16'h0000, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0001, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0000, 1'b0, NO_BEATS, '0},
			// length hit in the middle of a run, then a byte ignored and a new stream started
			'{ROW_LENGTH, 16'd525, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0031, 1'b0, ONE_BEAT, '{64'h0, 4'd2, 1'b1, 1'b1}},
			'{ROW_BYTE, 16'h00FF, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0071, 1'b1, ONE_BEAT, '{64'h0, 4'd7, 1'b1, 1'b0}},
			// length lowered below the position
			'{ROW_LENGTH, 16'd1, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h0044, 1'b0, NO_BEATS, '0},
			'{ROW_BYTE, 16'h001A, 1'b1, NO_BEATS, '0},
			'{ROW_BYTE, 16'h003C, 1'b0, ONE_BEAT, '{64'h003C, 4'd1, 1'b1, 1'b1}},
			'{ROW_BYTE, 16'h0010, 1'b0, NO_BEATS, '0}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			if (rows[r].kind == ROW_LENGTH)
				set_length(rows[r].val);
			else
				feed(rows[r].val[7:0], rows[r].sos, rows[r].beats, rows[r].beat);
		end

		goal = used_items;
		for (int p = 0; p < 4; p++) begin
			idle_pct  = IDLE_PCT[p];
			stall_pct = STALL_PCT[p];
			case (p)
				0: set_length(16'hFFFF);
				2: set_length(16'd24);
				default: set_length(16'($urandom_range(60, 700)));
			endcase
			goal += ITEMS_PER_PHASE;
			while (used_items < goal)
				random_token();
		end

		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_lz_zero_run_decompressor: clean");
		else
			$display("tb_lz_zero_run_decompressor: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: out_data %h valid_bytes %0d",
				       out_item.out_data, out_item.valid_bytes);
				errors++;
			end else begin
				want = expected_beats.pop_front();
				if (out_item.out_data !== want.out_data) begin
					$error("out_data: expected %h, got %h", want.out_data, out_item.out_data);
					errors++;
				end
				if (out_item.valid_bytes !== want.valid_bytes) begin
					$error("valid_bytes: expected %0d, got %0d",
					       want.valid_bytes, out_item.valid_bytes);
					errors++;
				end
				if (out_item.last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b",
					       want.last_of_run, out_item.last_of_run);
					errors++;
				end
				if (out_item.stream_done !== want.stream_done) begin
					$error("stream_done: expected %b, got %b",
					       want.stream_done, out_item.stream_done);
					errors++;
				end
			end
		end
	end

	initial begin
		#4_000_000;
		$display("tb_lz_zero_run_decompressor: errors");
		$finish;
	end

endmodule
